@@ hdl/savitzky_golay_smoother_macros.svh @@
// assertion macros shared by the smoother rtl
// every macro expects clk and rst in scope; checks are off while rst is high
`ifndef SAVITZKY_GOLAY_SMOOTHER_MACROS_SVH
`define SAVITZKY_GOLAY_SMOOTHER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SGS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SGS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/sgs_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, coefficient tables and types of the smoother
// no dependencies
package sgs_pkg;

  localparam int COEF_W = 9;
  localparam int DEN_W  = 11;
  localparam int HW_W   = 3;
  localparam int CNT_W  = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;
  localparam logic [HW_W-1:0]  HW_MIN  = 3'd2;

  // one row per half width 2..7, center coefficient first
  localparam logic signed [COEF_W-1:0] COEF_TAB [6][8] = '{
    '{ 9'sd17,  9'sd12,  -9'sd3,   9'sd0,   9'sd0,   9'sd0,   9'sd0,   9'sd0},
    '{ 9'sd7,   9'sd6,   9'sd3,    -9'sd2,  9'sd0,   9'sd0,   9'sd0,   9'sd0},
    '{ 9'sd59,  9'sd54,  9'sd39,   9'sd14,  -9'sd21, 9'sd0,   9'sd0,   9'sd0},
    '{ 9'sd89,  9'sd84,  9'sd69,   9'sd44,  9'sd9,   -9'sd36, 9'sd0,   9'sd0},
    '{ 9'sd25,  9'sd24,  9'sd21,   9'sd16,  9'sd9,   9'sd0,   -9'sd11, 9'sd0},
    '{ 9'sd167, 9'sd162, 9'sd147,  9'sd122, 9'sd87,  9'sd42,  -9'sd13, -9'sd78}
  };

  localparam logic [DEN_W-1:0] DEN_TAB [6] = '{
    11'd35, 11'd21, 11'd231, 11'd429, 11'd143, 11'd1105
  };

  typedef struct packed {
    logic last;
    logic too_short;
  } sgs_flags_t;

endpackage

@@ hdl/sgs_window.sv @@
`timescale 1ns / 1ps
// sample window, sequence bookkeeping and job issue with tap selection
// depends on sgs_pkg and the assertion macro header
`include "savitzky_golay_smoother_macros.svh"

module sgs_window import sgs_pkg::*; #(
  parameter int SAMPLE_BITS    = 16,
  parameter int MAX_HALF_WIDTH = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [HW_W-1:0]               half_width,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          last_in,
  output logic                          job_valid,
  input  logic                          job_ready,
  output logic signed [SAMPLE_BITS-1:0] job_mid,
  output logic signed [SAMPLE_BITS:0]   job_pair [MAX_HALF_WIDTH],
  output logic [HW_W-1:0]               job_half,
  output sgs_flags_t                    job_flags
);

  localparam int WIN = 2 * MAX_HALF_WIDTH + 1;

  logic signed [SAMPLE_BITS-1:0] window [WIN];
  logic [CNT_W-1:0] seen;
  logic [CNT_W-1:0] left;
  logic [HW_W-1:0]  center;
  logic             seq_end;
  logic             short_seq;

  logic [HW_W-1:0]  m_eff;
  logic [CNT_W-1:0] m_plus;
  logic [CNT_W-1:0] seen_base;
  logic [CNT_W-1:0] seen_next;
  logic [CNT_W-1:0] left_next;
  logic             ok;
  logic             issue_v;
  logic             slot_free;
  logic             issue;
  logic             final_issue;
  logic             accept;

  logic signed [SAMPLE_BITS-1:0] mid;
  logic signed [SAMPLE_BITS-1:0] far_tap  [MAX_HALF_WIDTH];
  logic signed [SAMPLE_BITS-1:0] near_tap [MAX_HALF_WIDTH];

  always_comb begin
    if (half_width < HW_MIN) begin
      m_eff = HW_MIN;
    end else if (half_width > HW_W'(MAX_HALF_WIDTH)) begin
      m_eff = HW_W'(MAX_HALF_WIDTH);
    end else begin
      m_eff = half_width;
    end
  end

  assign m_plus      = CNT_W'(m_eff) + CNT_W'(1);
  assign issue_v     = (left != '0);
  assign slot_free   = !job_valid || job_ready;
  assign issue       = issue_v && slot_free;
  assign final_issue = issue && (left == CNT_W'(1));
  assign in_stall    = issue_v && !final_issue;
  assign accept      = in_valid && !in_stall;

  // a sequence that ends this cycle frees the counters for a new first word
  assign seen_base = (final_issue && seq_end) ? '0 : seen;
  assign seen_next = (seen_base == CNT_MAX) ? CNT_MAX : seen_base + CNT_W'(1);
  assign ok        = (seen_next >= m_plus);

  always_comb begin
    if (last_in) begin
      left_next = ok ? m_plus : CNT_W'(1);
    end else begin
      left_next = ok ? CNT_W'(1) : '0;
    end
  end

  // taps around the current center; padding past the end uses the newest word
  always_comb begin
    mid = window[0];
    for (int k = 0; k < MAX_HALF_WIDTH; k++) begin
      far_tap[k]  = window[0];
      near_tap[k] = window[0];
    end
    for (int c = 0; c <= MAX_HALF_WIDTH; c++) begin
      if (center == HW_W'(c)) begin
        mid = window[c];
        for (int k = 1; k <= MAX_HALF_WIDTH; k++) begin
          far_tap[k-1]  = window[c + k];
          near_tap[k-1] = window[(k > c) ? 0 : c - k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen      <= '0;
      left      <= '0;
      center    <= '0;
      seq_end   <= 1'b0;
      short_seq <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      if (accept) begin
        seen      <= seen_next;
        left      <= left_next;
        center    <= m_eff;
        seq_end   <= last_in;
        short_seq <= last_in && !ok;
      end else if (issue) begin
        left   <= left - CNT_W'(1);
        center <= center - HW_W'(1);
        if (final_issue && seq_end) begin
          seen      <= '0;
          seq_end   <= 1'b0;
          short_seq <= 1'b0;
        end
      end
      if (slot_free) begin
        job_valid <= issue_v;
      end
    end
  end

  // first word of a sequence fills the whole window, so older taps pad to it
  always_ff @(posedge clk) begin
    if (accept) begin
      if (seen_base == '0) begin
        for (int i = 0; i < WIN; i++) begin
          window[i] <= sample;
        end
      end else begin
        window[0] <= sample;
        for (int i = 1; i < WIN; i++) begin
          window[i] <= window[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      job_mid   <= mid;
      job_half  <= m_eff;
      job_flags <= '{last: seq_end && (left == CNT_W'(1)), too_short: short_seq};
      for (int k = 0; k < MAX_HALF_WIDTH; k++) begin
        job_pair[k] <= (SAMPLE_BITS+1)'(far_tap[k]) + (SAMPLE_BITS+1)'(near_tap[k]);
      end
    end
  end

  `SGS_ASSERT_NEXT(a_last_starts_flush, accept && last_in, (left != '0) && seq_end, "last word left no pending flush")
  `SGS_ASSERT_NOW(a_short_is_last, job_valid && job_flags.too_short, job_flags.last, "too-short result not marked last")
  `SGS_ASSERT_NOW(a_left_bound, 1'b1, left <= CNT_W'(MAX_HALF_WIDTH + 1), "pending result count out of range")

endmodule

@@ hdl/sgs_mac.sv @@
`timescale 1ns / 1ps
// coefficient multiply, sum and magnitude with half denominator for rounding
// depends on sgs_pkg
module sgs_mac import sgs_pkg::*; #(
  parameter int SAMPLE_BITS    = 16,
  parameter int MAX_HALF_WIDTH = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_mid,
  input  logic signed [SAMPLE_BITS:0]   in_pair [MAX_HALF_WIDTH],
  input  logic [HW_W-1:0]               in_half,
  input  sgs_flags_t                    in_flags,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [SAMPLE_BITS+DEN_W-1:0]  out_mag,
  output logic [HW_W-1:0]               out_row,
  output logic                          out_neg,
  output sgs_flags_t                    out_flags
);

  localparam int PAIR_W = SAMPLE_BITS + 1;
  localparam int PROD_W = PAIR_W + COEF_W;
  localparam int SUM_W  = PROD_W + 3;
  localparam int MAG_W  = SAMPLE_BITS + DEN_W;

  logic v2, v3;
  logic r2, r3, r4;

  logic signed [PROD_W-1:0] p2 [MAX_HALF_WIDTH+1];
  logic [HW_W-1:0]          h2, h3;
  sgs_flags_t               f2, f3;
  logic signed [SUM_W-1:0]  s3;
  logic signed [SUM_W-1:0]  sum_c;
  logic signed [SUM_W-1:0]  abs_c;
  logic [HW_W-1:0]          row_in;
  logic [HW_W-1:0]          row3;

  assign r4       = !out_valid || out_ready;
  assign r3       = !v3 || r4;
  assign r2       = !v2 || r3;
  assign in_ready = r2;

  assign row_in = in_half - HW_MIN;
  assign row3   = h3 - HW_MIN;

  always_comb begin
    sum_c = '0;
    for (int k = 0; k <= MAX_HALF_WIDTH; k++) begin
      sum_c = sum_c + SUM_W'(p2[k]);
    end
  end

  assign abs_c = s3[SUM_W-1] ? -s3 : s3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r2) begin
        v2 <= in_valid;
      end
      if (r3) begin
        v3 <= v2;
      end
      if (r4) begin
        out_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r2) begin
      p2[0] <= PROD_W'(in_mid) * PROD_W'(COEF_TAB[row_in][0]);
      for (int k = 1; k <= MAX_HALF_WIDTH; k++) begin
        p2[k] <= PROD_W'(in_pair[k-1]) * PROD_W'(COEF_TAB[row_in][HW_W'(k)]);
      end
      h2 <= in_half;
      f2 <= in_flags;
    end
    if (r3) begin
      s3 <= sum_c;
      h3 <= h2;
      f3 <= f2;
    end
    if (r4) begin
      out_mag   <= MAG_W'($unsigned(abs_c)) + MAG_W'(DEN_TAB[row3] >> 1);
      out_row   <= row3;
      out_neg   <= s3[SUM_W-1];
      out_flags <= f3;
    end
  end

endmodule

@@ hdl/sgs_divide.sv @@
`timescale 1ns / 1ps
// reciprocal multiply by the frame denominator, then shift and saturation
// depends on sgs_pkg and the assertion macro header
`include "savitzky_golay_smoother_macros.svh"

module sgs_divide import sgs_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [SAMPLE_BITS+DEN_W-1:0]  in_mag,
  input  logic [HW_W-1:0]               in_row,
  input  logic                          in_neg,
  input  sgs_flags_t                    in_flags,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] smoothed,
  output logic                          last_out,
  output logic                          too_short
);

  localparam int MAG_W   = SAMPLE_BITS + DEN_W;
  // rounded magnitudes stay below 2^(SAMPLE_BITS+10) for every frame
  localparam int NUM_W   = SAMPLE_BITS + 10;
  localparam int RECIP_W = SAMPLE_BITS + 11;
  localparam int PROD_W  = MAG_W + RECIP_W;
  localparam int SHIFT_W = $clog2(PROD_W);

  logic [RECIP_W-1:0] recip_tab [6];
  logic [SHIFT_W-1:0] shift_tab [6];

  logic                   r1;
  logic                   r_out;
  logic                   v1;
  logic [PROD_W-1:0]      prod1;
  logic [SHIFT_W-1:0]     shift1;
  logic                   neg1;
  sgs_flags_t             flags1;

  logic [PROD_W-1:0]             quo_full;
  logic [SAMPLE_BITS-1:0]        q_fin;
  logic signed [SAMPLE_BITS-1:0] sat_max;
  logic signed [SAMPLE_BITS-1:0] sat_min;
  logic signed [SAMPLE_BITS-1:0] value;

  // ceil(2^shift / den) with shift = NUM_W + clog2(den) gives the exact floor
  // quotient for every dividend below 2^NUM_W
  for (genvar r = 0; r < 6; r++) begin : g_recip
    localparam int     SHIFT = NUM_W + $clog2(DEN_TAB[r]);
    localparam longint DEN   = longint'(DEN_TAB[r]);
    localparam longint RECIP = ((longint'(1) << SHIFT) + DEN - longint'(1)) / DEN;
    assign recip_tab[r] = RECIP_W'(RECIP);
    assign shift_tab[r] = SHIFT_W'(SHIFT);
  end

  assign r_out    = !out_valid || out_ready;
  assign r1       = !v1 || r_out;
  assign in_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r1) begin
        v1 <= in_valid;
      end
      if (r_out) begin
        out_valid <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      prod1  <= PROD_W'(in_mag) * PROD_W'(recip_tab[in_row]);
      shift1 <= shift_tab[in_row];
      neg1   <= in_neg;
      flags1 <= in_flags;
    end
  end

  assign quo_full = prod1 >> shift1;
  assign q_fin    = quo_full[SAMPLE_BITS-1:0];
  assign sat_max  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  assign sat_min  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // a quotient reaching the sign bit is out of range either way
  always_comb begin
    if (flags1.too_short) begin
      value = '0;
    end else if (q_fin[SAMPLE_BITS-1]) begin
      value = neg1 ? sat_min : sat_max;
    end else if (neg1) begin
      value = -$signed(q_fin);
    end else begin
      value = $signed(q_fin);
    end
  end

  always_ff @(posedge clk) begin
    if (r_out) begin
      smoothed  <= value;
      last_out  <= flags1.last;
      too_short <= flags1.too_short;
    end
  end

  `SGS_ASSERT_NOW(a_out_short_last, out_valid && too_short, last_out, "too-short result without last mark")
  `SGS_ASSERT_NOW(a_out_short_zero, out_valid && too_short, smoothed == '0, "too-short result not zero")
  `SGS_ASSERT_NOW(a_dividend_bound, in_valid && in_ready, in_mag < (MAG_W'(1) << NUM_W), "dividend exceeds reciprocal range")

endmodule

@@ hdl/savitzky_golay_smoother.sv @@
`timescale 1ns / 1ps
// top level of the streaming quadratic savitzky-golay smoother
// depends on sgs_pkg, sgs_window, sgs_mac and sgs_divide
//
// Takes one signed sample word per unstalled clock and returns the quadratic
// Savitzky-Golay smoothed sequence, rounded to nearest and saturated, with
// edges padded by the first and last sample. Results lag the input by the
// half width m (cfg_wdata 0 or 1 acts as 2, above MAX_HALF_WIDTH acts as
// MAX_HALF_WIDTH); write it only while the block is idle. Sustained rate is
// one word in and one word out per cycle without stalls. A word marked
// last_in releases the m pending results, so the input stalls while those
// jobs issue from the window registers, one per unstalled cycle, into the
// single multiply-accumulate pipeline. A sequence with fewer than m+1 words
// gives one word with too_short and last_out set and smoothed at 0. A result
// word is registered after each step in order: tap select, multiply, sum,
// rounding magnitude, reciprocal multiply by the frame denominator, then
// shift and saturation into the output register.
module savitzky_golay_smoother import sgs_pkg::*; #(
  parameter int SAMPLE_BITS    = 16,
  parameter int MAX_HALF_WIDTH = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [HW_W-1:0]               cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          last_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] smoothed,
  output logic                          last_out,
  output logic                          too_short
);

  localparam int MAG_W = SAMPLE_BITS + DEN_W;

  logic [HW_W-1:0] half_width;

  logic                          job_valid;
  logic                          job_ready;
  logic signed [SAMPLE_BITS-1:0] job_mid;
  logic signed [SAMPLE_BITS:0]   job_pair [MAX_HALF_WIDTH];
  logic [HW_W-1:0]               job_half;
  sgs_flags_t                    job_flags;

  logic             mac_valid;
  logic             mac_ready;
  logic [MAG_W-1:0] mac_mag;
  logic [HW_W-1:0]  mac_row;
  logic             mac_neg;
  sgs_flags_t       mac_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width <= HW_MIN;
    end else if (cfg_we) begin
      half_width <= cfg_wdata;
    end
  end

  sgs_window #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .MAX_HALF_WIDTH (MAX_HALF_WIDTH)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .half_width (half_width),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample     (sample),
    .last_in    (last_in),
    .job_valid  (job_valid),
    .job_ready  (job_ready),
    .job_mid    (job_mid),
    .job_pair   (job_pair),
    .job_half   (job_half),
    .job_flags  (job_flags)
  );

  sgs_mac #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .MAX_HALF_WIDTH (MAX_HALF_WIDTH)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (job_valid),
    .in_ready  (job_ready),
    .in_mid    (job_mid),
    .in_pair   (job_pair),
    .in_half   (job_half),
    .in_flags  (job_flags),
    .out_valid (mac_valid),
    .out_ready (mac_ready),
    .out_mag   (mac_mag),
    .out_row   (mac_row),
    .out_neg   (mac_neg),
    .out_flags (mac_flags)
  );

  sgs_divide #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_divide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mac_valid),
    .in_ready  (mac_ready),
    .in_mag    (mac_mag),
    .in_row    (mac_row),
    .in_neg    (mac_neg),
    .in_flags  (mac_flags),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .smoothed  (smoothed),
    .last_out  (last_out),
    .too_short (too_short)
  );

endmodule

@@ dv/savitzky_golay_smoother_test.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the streaming quadratic savitzky-golay smoother
// depends on sgs_pkg and savitzky_golay_smoother; predicts every result word itself
module savitzky_golay_smoother_test import sgs_pkg::*;;

  localparam int SW            = 16;
  localparam int WIN_DEPTH     = 15;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_SEQ_LEN   = 40;

  // quadratic frame coefficients per half width 2..7, center tap first
  localparam int SG_COEF [6][8] = '{
    '{17, 12, -3, 0, 0, 0, 0, 0},
    '{7, 6, 3, -2, 0, 0, 0, 0},
    '{59, 54, 39, 14, -21, 0, 0, 0},
    '{89, 84, 69, 44, 9, -36, 0, 0},
    '{25, 24, 21, 16, 9, 0, -11, 0},
    '{167, 162, 147, 122, 87, 42, -13, -78}
  };
  localparam int SG_DEN [6] = '{35, 21, 231, 429, 143, 1105};

  localparam int DIRECTED_PEAKS [10] = '{
    0, -32768, 32767, 32767, 32767, -32768, -32768, -32768, 32767, -1
  };
  localparam int WIDTH_PLAN [10] = '{1, 4, 0, 6, 3, 5, 2, 7, 7, 2};

  typedef struct {
    logic signed [SW-1:0] value;
    logic                 last;
  } sample_word_t;

  typedef struct {
    logic signed [SW-1:0] value;
    logic                 last;
    logic                 short_seq;
  } smoothed_word_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_we = 1'b0;
  logic [HW_W-1:0] cfg_wdata = '0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic signed [SW-1:0] sample = '0;
  logic            last_in = 1'b0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic signed [SW-1:0] smoothed;
  logic            last_out;
  logic            too_short;

  sample_word_t   pending_words[$];
  smoothed_word_t expected_results[$];
  sample_word_t   tx_word;

  // predictor state
  logic [HW_W-1:0] width_reg = HW_W'(2);
  longint          win [WIN_DEPTH];
  int              seen_cnt = 0;
  longint          first_val = 0;

  logic in_taken = 1'b0;
  logic tx_idling = 1'b1;
  logic rx_idling = 1'b1;
  logic hold_off = 1'b0;
  logic pressure_go = 1'b0;
  int   tx_gap = 0;
  int   stall_left = 0;

  int errors = 0;
  int words_queued = 0;
  int sequences = 0;
  int results_checked = 0;
  int short_results = 0;
  int widths_used = 1;

  savitzky_golay_smoother u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .last_in   (last_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .smoothed  (smoothed),
    .last_out  (last_out),
    .too_short (too_short)
  );

  always #5 clk = ~clk;

  initial begin
    foreach (win[i]) win[i] = 0;
  end

  // mostly short idles, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(1, 2);
    if (r < 9) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  // sample by age, 0 being the newest; older than the sequence reads as its first word
  function automatic longint tap(int age);
    if (age < seen_cnt && age < WIN_DEPTH) return win[age];
    return first_val;
  endfunction

  function automatic logic signed [SW-1:0] smooth_at(int m, int center);
    longint acc, mag, q, den, newer;
    int k;
    acc = SG_COEF[m-2][0] * tap(center);
    den = SG_DEN[m-2];
    for (k = 1; k <= m; k++) begin
      // past the newest sample the sequence holds its last value
      newer = (k > center) ? tap(0) : tap(center - k);
      acc += SG_COEF[m-2][k] * (tap(center + k) + newer);
    end
    mag = (acc < 0) ? -acc : acc;
    q = (mag + den / 2) / den;
    if (acc < 0) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[SW-1:0];
  endfunction

  function automatic void push_result(logic signed [SW-1:0] v, logic l, logic s);
    smoothed_word_t r;
    r.value = v;
    r.last = l;
    r.short_seq = s;
    expected_results.push_back(r);
  endfunction

  task automatic predict_word(logic signed [SW-1:0] x, logic l);
    int m, c, i;
    m = (width_reg < 2) ? 2 : int'(width_reg);
    if (seen_cnt == 0) first_val = x;
    for (i = WIN_DEPTH - 1; i > 0; i--) win[i] = win[i-1];
    win[0] = x;
    if (seen_cnt < 15) seen_cnt++;
    if (seen_cnt >= m + 1) push_result(smooth_at(m, m), 1'b0, 1'b0);
    if (l) begin
      if (seen_cnt < m + 1) begin
        push_result('0, 1'b1, 1'b1);
      end else begin
        for (c = m - 1; c >= 0; c--) push_result(smooth_at(m, c), c == 0, 1'b0);
      end
      foreach (win[j]) win[j] = 0;
      seen_cnt = 0;
      first_val = 0;
    end
  endtask

  task automatic note_error(string msg);
    if (errors < 10) $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_word();
    smoothed_word_t e;
    if (expected_results.size() == 0) begin
      note_error($sformatf("unexpected word smoothed=%0d last_out=%0b too_short=%0b",
                           smoothed, last_out, too_short));
    end else begin
      e = expected_results.pop_front();
      if (e.value !== smoothed || e.last !== last_out || e.short_seq !== too_short)
        note_error($sformatf("result %0d expected %0d/%0b/%0b got %0d/%0b/%0b",
                             results_checked, e.value, e.last, e.short_seq,
                             smoothed, last_out, too_short));
      if (e.short_seq) short_results++;
    end
    results_checked++;
  endtask

  // monitor: accepted words on both channels, config writes
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (cfg_we) width_reg = cfg_wdata;
      if (in_valid && !in_stall) predict_word(sample, last_in);
      if (out_valid && !out_stall) check_word();
    end
  end

  // sender: holds a word until taken, then idles or moves to the next one
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (tx_gap != 0) begin
        tx_gap <= tx_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        tx_word = pending_words.pop_front();
        in_valid <= 1'b1;
        sample <= tx_word.value;
        last_in <= tx_word.last;
        tx_gap <= (tx_idling && $urandom_range(0, 2) == 0) ? gap_len() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (rx_idling && $urandom_range(0, 3) == 0) begin
      stall_left <= gap_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= hold_off;
    end
  end

  // long receiver hold-off so the pipeline backs up into the input
  initial begin
    wait (pressure_go);
    @(negedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_off <= 1'b0;
  end

  task automatic add_word(int v, logic l);
    sample_word_t w;
    w.value = v[SW-1:0];
    w.last = l;
    pending_words.push_back(w);
    words_queued++;
    if (l) sequences++;
  endtask

  task automatic queue_sequence(int len);
    int kind, i, walk, v;
    kind = $urandom_range(0, 3);
    walk = $urandom_range(0, 65535) - 32768;
    for (i = 0; i < len; i++) begin
      case (kind)
        0: v = $urandom_range(0, 65535) - 32768;
        1: begin
          // slow drift, clipped at the rails
          walk = walk + $urandom_range(0, 4000) - 2000;
          if (walk > 32767) walk = 32767;
          if (walk < -32768) walk = -32768;
          v = walk;
        end
        2: v = $urandom_range(0, 1) ? 32767 : -32768;
        default: v = $urandom_range(0, 200) - 100;
      endcase
      add_word(v, i == len - 1);
    end
  endtask

  task automatic write_width(int v);
    @(negedge clk);
    cfg_wdata <= v[HW_W-1:0];
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    widths_used++;
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random_phase(int setting, int n_words);
    int eff, queued, len;
    eff = (setting < 2) ? 2 : setting;
    queued = 0;
    while (queued < n_words) begin
      if ($urandom_range(0, 5) == 0) len = $urandom_range(1, eff);
      else len = $urandom_range(eff + 1, MAX_SEQ_LEN);
      queue_sequence(len);
      queued += len;
    end
    drain();
  endtask

  initial begin
    int p;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset width: saturating peaks of both signs, then too-short and minimal sequences
    foreach (DIRECTED_PEAKS[i]) add_word(DIRECTED_PEAKS[i], i == 9);
    add_word(-32768, 1'b1);
    add_word(32767, 1'b0);
    add_word(0, 1'b1);
    add_word(1, 1'b0);
    add_word(-1, 1'b0);
    add_word(32767, 1'b1);
    drain();

    // widest frame, shortest sequence that still smooths
    write_width(7);
    for (p = 0; p < 8; p++) add_word((p % 2) ? 32767 : -32768, p == 7);
    drain();

    for (p = 0; p < 10; p++) begin
      write_width(WIDTH_PLAN[p]);
      tx_idling = (p != 2 && p != 5);
      rx_idling = (p != 2 && p != 5);
      if (p == 2) pressure_go = 1'b1;
      run_random_phase(WIDTH_PLAN[p], (p == 2) ? 60 : 40);
    end

    $display("covered %0d words in %0d sequences over %0d width writes incl. a long hold-off",
             words_queued, sequences, widths_used - 1);
    $display("checked %0d result words, %0d of them flagged too short",
             results_checked, short_results);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/sgs_pkg.sv
hdl/sgs_window.sv
hdl/sgs_mac.sv
hdl/sgs_divide.sv
hdl/savitzky_golay_smoother.sv
dv/savitzky_golay_smoother_test.sv
